// File: src/ttip_pkg.sv
// Package for the text-to-integer parser: parse phases, character codes,
// per-string state record and character classification functions.
// No dependencies.
package ttip_pkg;

	// Longest string position tracked; position counter saturates here
	localparam int MaxLen = 4096;
	localparam int PosW   = $clog2(MaxLen + 1);
	localparam int ValW   = 64;
	localparam int RadW   = 6;

	// Configuration register indexes
	localparam logic CfgBaseSelect = 1'b0;
	localparam logic CfgSignedMode = 1'b1;

	// Radix values
	localparam logic [RadW-1:0] RadixOct = RadW'(8);
	localparam logic [RadW-1:0] RadixDec = RadW'(10);
	localparam logic [RadW-1:0] RadixHex = RadW'(16);
	localparam logic [RadW-1:0] RadixMax = RadW'(36);
	localparam logic [RadW-1:0] RadixOne = RadW'(1);
	// digit value of a non-digit character
	localparam logic [RadW-1:0] DigitNone = RadW'(36);

	// Character codes
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	// offsets that map letters onto digit values 10..35
	localparam logic [7:0] OffUpper = 8'h37;
	localparam logic [7:0] OffLower = 8'h57;

	// Parse phase, one-hot
	typedef enum logic [5:0] {
		PH_SPACE  = 6'b000001,
		PH_FIRST  = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_AFTERX = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	// Per-string parse state
	typedef struct packed {
		phase_t            phase;
		logic [ValW-1:0]   acc;
		logic              neg;
		logic [RadW-1:0]   radix;
		logic              any;
		logic [PosW-1:0]   pos;
		logic [PosW-1:0]   end_pos;
	} ttip_state_t;

	localparam ttip_state_t StateReset = '{
		phase:   PH_SPACE,
		acc:     '0,
		neg:     1'b0,
		radix:   '0,
		any:     1'b0,
		pos:     '0,
		end_pos: '0
	};

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_blank(input logic [7:0] c);
		return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
	endfunction

	// Digit value 0..35, DigitNone for anything else
	function automatic logic [RadW-1:0] digit_value(input logic [7:0] c);
		logic [RadW-1:0] v;
		case (c) inside
			[ChZero:ChNine]: v = RadW'(c - ChZero);
			[ChUpA:ChUpZ]:   v = RadW'(c - OffUpper);
			[ChLowA:ChLowZ]: v = RadW'(c - OffLower);
			default:         v = DigitNone;
		endcase
		return v;
	endfunction

endpackage

// File: src/ttip_step.sv
// Next-state logic of the parser for one character: phase decisions and the
// single multiply-add that folds a digit into the accumulator.
// Depends on ttip_pkg.
module ttip_step
	import ttip_pkg::*;
(
	input  ttip_state_t       cur,
	input  logic [7:0]        char_code,
	input  logic [RadW-1:0]   base_select,
	input  logic              signed_mode,
	output ttip_state_t       nxt
);

	logic [RadW-1:0] dv;
	logic            in_range;
	logic            base_bad;
	logic            zero_lead;
	logic            opening;
	logic            is_sign;
	logic [RadW-1:0] first_radix;
	logic [RadW-1:0] use_radix;
	logic            digit_ok;
	logic [ValW-1:0] acc_mac;
	logic [PosW-1:0] pos_inc;

	assign dv       = digit_value(char_code);
	assign in_range = cur.pos < PosW'(MaxLen);
	assign pos_inc  = cur.pos + PosW'(1);
	assign is_sign  = (char_code == ChPlus) || (char_code == ChMinus);

	// First non-blank, non-sign character picks the radix
	assign base_bad    = (base_select == RadixOne) || (base_select > RadixMax);
	assign zero_lead   = ((base_select == '0) || (base_select == RadixHex))
		&& (char_code == ChZero) && in_range;
	assign first_radix = (base_select == '0) ? RadixDec : base_select;
	assign opening     = (cur.phase == PH_SPACE) || (cur.phase == PH_FIRST);

	// Shared digit path: accumulator is zero while still opening
	assign use_radix = opening ? first_radix : cur.radix;
	assign digit_ok  = in_range && (dv < use_radix);
	assign acc_mac   = ValW'(cur.acc * ValW'(use_radix)) + ValW'(dv);

	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_SPACE, PH_FIRST: begin
				if ((cur.phase == PH_SPACE) && is_blank(char_code)) begin
					nxt.phase = PH_SPACE;
				end else if ((cur.phase == PH_SPACE) && signed_mode && is_sign) begin
					nxt.neg   = (char_code == ChMinus);
					nxt.phase = PH_FIRST;
				end else if (base_bad) begin
					nxt.phase = PH_DONE;
				end else if (zero_lead) begin
					nxt.radix   = (base_select == '0) ? RadixOct : RadixHex;
					nxt.any     = 1'b1;
					nxt.acc     = '0;
					nxt.end_pos = pos_inc;
					nxt.phase   = PH_ZERO;
				end else begin
					nxt.radix = first_radix;
					if (digit_ok) begin
						nxt.acc     = acc_mac;
						nxt.any     = 1'b1;
						nxt.end_pos = pos_inc;
						nxt.phase   = PH_DIGITS;
					end else begin
						nxt.phase = PH_DONE;
					end
				end
			end
			PH_ZERO, PH_AFTERX, PH_DIGITS: begin
				if ((cur.phase == PH_ZERO) && in_range
					&& ((char_code == ChLowX) || (char_code == ChUpX))) begin
					nxt.radix = RadixHex;
					nxt.phase = PH_AFTERX;
				end else if (digit_ok) begin
					nxt.acc     = acc_mac;
					nxt.any     = 1'b1;
					nxt.end_pos = pos_inc;
					nxt.phase   = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			default: begin
				nxt.phase = PH_DONE;
			end
		endcase

		// position counter saturates at the length limit
		if (in_range) begin
			nxt.pos = pos_inc;
		end
	end

endmodule

// File: src/text_to_integer_parser.sv
// Top level of the streaming text-to-integer parser: input register, parse
// state, configuration registers and the result register.
// Depends on ttip_pkg and ttip_step.
//
//  channel | direction | payload                          | beats
//  --------+-----------+----------------------------------+---------------------
//  in      | to block  | char_code, last_char             | one per character
//  out     | from block| value, digits_found, end_offset  | one per last_char
//  cfg     | to block  | cfg_index, cfg_data              | write on cfg_we
//
// One character beat per cycle while in_stall is low. A beat is registered,
// then folded into the parse state through one 64x6 multiply-add; a last_char
// beat loads the result register in that same cycle.
// Reset clears the parse state, configuration and valid flags.
// in_stall rises only while a last_char beat waits behind an unaccepted result.
module text_to_integer_parser
	import ttip_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ValW-1:0]   value,
	output logic              digits_found,
	output logic [PosW-1:0]   end_offset,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [RadW-1:0]   cfg_data
);

	logic [RadW-1:0] base_q;
	logic            signed_q;
	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            last_s1;
	logic            advance;
	ttip_state_t     state_q;
	ttip_state_t     state_nxt;
	logic            out_valid_q;
	logic [ValW-1:0] acc_q;
	logic            neg_q;
	logic            any_q;
	logic [PosW-1:0] end_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgBaseSelect: base_q   <= cfg_data;
				CfgSignedMode: signed_q <= cfg_data[0];
				default:       base_q   <= base_q;
			endcase
		end
	end

	// Stage 1 holds only when its closing beat cannot reach the result register
	assign advance  = !(valid_s1 && last_s1 && out_valid_q && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// Next parse state for the registered character
	ttip_step u_step (
		.cur         (state_q),
		.char_code   (char_s1),
		.base_select (base_q),
		.signed_mode (signed_q),
		.nxt         (state_nxt)
	);

	// Parse state; back to reset once a string closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (valid_s1 && advance) begin
			state_q <= last_s1 ? StateReset : state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && advance) begin
			acc_q <= state_nxt.acc;
			neg_q <= state_nxt.neg;
			any_q <= state_nxt.any;
			end_q <= state_nxt.end_pos;
		end
	end

	// Sign applied on the way out
	assign out_valid    = out_valid_q;
	assign value        = neg_q ? (ValW'(0) - acc_q) : acc_q;
	assign digits_found = any_q;
	assign end_offset   = any_q ? end_q : '0;

endmodule

// File: dv/tb_text_to_integer_parser.sv
// Self-checking testbench for text_to_integer_parser: strings are streamed one
// character per beat and each result is checked against a predictor in a class.
// Depends on ttip_pkg and the text_to_integer_parser RTL.
module tb_text_to_integer_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import ttip_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 300;

	typedef logic [7:0] text_t[$];

	// One parsed number as the result channel delivers it
	typedef struct {
		logic [ValW-1:0] value;
		logic            found;
		logic [PosW-1:0] offset;
	} number_t;

	// Predicts the parse of each string and checks the results in order
	class parse_tracker;
		phase_t          stage;
		logic [ValW-1:0] acc;
		logic            neg;
		logic [RadW-1:0] radix;
		logic            digit_seen;
		logic [PosW-1:0] pos;
		logic [PosW-1:0] end_pos;
		logic [RadW-1:0] base_sel;
		logic            sign_ok;
		number_t         pending_numbers[$];
		int              mismatches;
		int              strings;
		int              checked;

		function new();
			base_sel = '0;
			sign_ok = 1'b0;
			mismatches = 0;
			strings = 0;
			checked = 0;
			clear();
		endfunction

		function void clear();
			stage = PH_SPACE;
			acc = '0;
			neg = 1'b0;
			radix = '0;
			digit_seen = 1'b0;
			pos = '0;
			end_pos = '0;
		endfunction

		function void write_reg(logic idx, logic [RadW-1:0] d);
			if (idx == CfgBaseSelect) begin
				base_sel = d;
			end else begin
				sign_ok = d[0];
			end
		endfunction

		// Fold one character into the accumulator, or end the number
		function void add_digit(logic [7:0] c, logic [PosW-1:0] at);
			int d;
			if (c >= ChZero && c <= ChNine) begin
				d = c - ChZero;
			end else if (c >= ChUpA && c <= ChUpZ) begin
				d = c - OffUpper;
			end else if (c >= ChLowA && c <= ChLowZ) begin
				d = c - OffLower;
			end else begin
				d = 36;
			end
			if (at >= MaxLen || d >= radix) begin
				stage = PH_DONE;
				return;
			end
			acc = acc * ValW'(radix) + ValW'(d);
			digit_seen = 1'b1;
			end_pos = at + 1'b1;
			stage = PH_DIGITS;
		endfunction

		// First character past blanks and sign: radix is fixed here
		function void open_number(logic [7:0] c, logic [PosW-1:0] at);
			if (base_sel == RadixOne || base_sel > RadixMax) begin
				stage = PH_DONE;
				return;
			end
			if ((base_sel == '0 || base_sel == RadixHex) && c == ChZero && at < MaxLen) begin
				radix = (base_sel == '0) ? RadixOct : RadixHex;
				digit_seen = 1'b1;
				acc = '0;
				end_pos = at + 1'b1;
				stage = PH_ZERO;
				return;
			end
			radix = (base_sel == '0) ? RadixDec : base_sel;
			add_digit(c, at);
		endfunction

		// Note one accepted character beat
		function void take_char(logic [7:0] c, logic last);
			logic [PosW-1:0] at;
			number_t         done_n;
			at = pos;
			case (stage)
				PH_SPACE: begin
					if (!(c == ChSpace || (c >= ChTab && c <= ChCr))) begin
						if (sign_ok && (c == ChMinus || c == ChPlus)) begin
							neg = (c == ChMinus);
							stage = PH_FIRST;
						end else begin
							open_number(c, at);
						end
					end
				end
				PH_FIRST: open_number(c, at);
				PH_ZERO: begin
					if ((c == ChLowX || c == ChUpX) && at < MaxLen) begin
						radix = RadixHex;
						stage = PH_AFTERX;
					end else begin
						add_digit(c, at);
					end
				end
				PH_AFTERX, PH_DIGITS: add_digit(c, at);
				default: stage = PH_DONE;
			endcase
			if (pos < MaxLen) pos = at + 1'b1;
			if (last) begin
				done_n.value = neg ? ValW'(0) - acc : acc;
				done_n.found = digit_seen;
				done_n.offset = digit_seen ? end_pos : '0;
				pending_numbers.push_back(done_n);
				strings++;
				clear();
			end
		endfunction

		// Compare one accepted result beat with the oldest prediction
		function void check_result(logic [ValW-1:0] v, logic f, logic [PosW-1:0] e);
			number_t want;
			if (pending_numbers.size() == 0) begin
				$display("%0t: result with no string pending: value %h found %b offset %0d",
					$time, v, f, e);
				mismatches++;
				return;
			end
			want = pending_numbers.pop_front();
			checked++;
			if (v !== want.value) begin
				$display("%0t: value expected %h actual %h", $time, want.value, v);
				mismatches++;
			end
			if (f !== want.found) begin
				$display("%0t: digits_found expected %b actual %b", $time, want.found, f);
				mismatches++;
			end
			if (e !== want.offset) begin
				$display("%0t: end_offset expected %0d actual %0d", $time, want.offset, e);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_numbers.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [7:0]      char_code;
	logic            last_char;
	logic            out_valid;
	logic            out_stall;
	logic [ValW-1:0] value;
	logic            digits_found;
	logic [PosW-1:0] end_offset;
	logic            cfg_we;
	logic            cfg_index;
	logic [RadW-1:0] cfg_data;

	parse_tracker    tracker = new();
	int              snd_idle = 0;
	int              rcv_idle = 0;
	bit              hold_req = 1'b0;
	int              beats = 0;
	int              cycle_count = 0;
	logic [RadW-1:0] cur_base = '0;

	text_to_integer_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.digits_found (digits_found),
		.end_offset   (end_offset),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("%0t: timeout after %0d cycles", $time, CycleLimit);
			$display("tb_text_to_integer_parser failed");
			$finish;
		end
	end

	// Result side stall: random, or a long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(value, digits_found, end_offset);
	end

	function automatic text_t as_bytes(string t);
		text_t s;
		for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
		return s;
	endfunction

	// Mostly well-formed numbers for the current radix, some noise and broken openings
	function automatic text_t random_text();
		text_t      s;
		int         kind;
		int         n;
		int         radix;
		int         d;
		logic [7:0] blanks[6] = '{ChSpace, ChTab, 8'h0A, 8'h0B, 8'h0C, ChCr};
		logic [7:0] tricky[7] = '{ChPlus, ChMinus, ChSpace, ChZero, ChLowX, ChUpX, ChTab};
		kind = $urandom_range(9);
		if (kind < 7) begin
			repeat ($urandom_range(2)) s.push_back(blanks[$urandom_range(5)]);
			if ($urandom_range(2) == 0) s.push_back($urandom_range(1) ? ChMinus : ChPlus);
			if (cur_base == '0) begin
				radix = RadixDec;
			end else if (cur_base == RadixOne || cur_base > RadixMax) begin
				radix = RadixMax;
			end else begin
				radix = cur_base;
			end
			// optional prefix where the radix allows one
			if ((cur_base == '0 || cur_base == RadixHex) && $urandom_range(1)) begin
				s.push_back(ChZero);
				if ($urandom_range(2) != 0) begin
					s.push_back($urandom_range(1) ? ChLowX : ChUpX);
					radix = RadixHex;
				end else if (cur_base == '0) begin
					radix = RadixOct;
				end
			end
			n = ($urandom_range(7) == 0) ? $urandom_range(14, 26) : $urandom_range(0, 6);
			repeat (n) begin
				d = $urandom_range(radix - 1);
				if (d < 10)
					s.push_back(8'(ChZero + d));
				else
					s.push_back(8'(($urandom_range(1) ? ChUpA : ChLowA) + d - 10));
			end
			repeat ($urandom_range(2)) s.push_back(8'($urandom_range(255)));
		end else if (kind < 9) begin
			repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 4)) s.push_back(tricky[$urandom_range(6)]);
			s.push_back(8'($urandom_range(255)));
		end
		return s;
	endfunction

	// One character beat, with a random gap before it
	task automatic send_beat(logic [7:0] c, logic last);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= last;
		do @(posedge clk); while (in_stall);
		tracker.take_char(c, last);
		beats++;
	endtask

	task automatic send_bytes(text_t s);
		for (int i = 0; i < s.size(); i++) send_beat(s[i], i == s.size() - 1);
	endtask

	// Stop offering and let every outstanding result come out
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; only called while idle
	task automatic set_parse_mode(logic [RadW-1:0] base, logic sgn);
		cfg_we <= 1'b1;
		cfg_index <= CfgBaseSelect;
		cfg_data <= base;
		@(posedge clk);
		tracker.write_reg(CfgBaseSelect, base);
		cfg_index <= CfgSignedMode;
		cfg_data <= RadW'(sgn);
		@(posedge clk);
		tracker.write_reg(CfgSignedMode, RadW'(sgn));
		cfg_we <= 1'b0;
		cur_base = base;
	endtask

	// Stimulus
	initial begin
		text_t           s;
		int              sent;
		logic [RadW-1:0] base;
		logic [RadW-1:0] first_base[3];
		first_base = '{RadW'(0), RadixMax, RadW'(2)};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_code <= '0;
		last_char <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CfgBaseSelect;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: prefixes, signs, blanks, extreme bytes, radix limits
		set_parse_mode(RadW'(0), 1'b0);
		send_bytes(as_bytes("0x"));
		send_bytes(as_bytes("-5"));
		send_bytes(as_bytes("\t 017"));
		send_bytes(as_bytes("0X1F"));
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b1);
		drain();
		set_parse_mode(RadixHex, 1'b1);
		send_bytes(as_bytes("-0x"));
		send_bytes(as_bytes("+ 7"));
		send_bytes(as_bytes("0xg"));
		drain();
		set_parse_mode(RadixMax, 1'b1);
		send_bytes(as_bytes("-zzzzzzzzzzzzz"));
		send_bytes(as_bytes("Zz!9"));
		drain();
		set_parse_mode(RadW'(2), 1'b0);
		send_bytes(as_bytes("1012"));
		drain();
		set_parse_mode(RadixOne, 1'b1);
		send_bytes(as_bytes("11"));
		drain();
		set_parse_mode(RadW'(63), 1'b0);
		send_bytes(as_bytes("5"));
		drain();

		// Random: receiver-heavy gaps, sender-heavy gaps, then none
		for (int mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 35 : (mode == 1) ? 52 : 0;
			rcv_idle = (mode == 0) ? 52 : (mode == 1) ? 35 : 0;
			for (int k = 0; k < 3; k++) begin
				drain();
				if (k == 0) begin
					base = first_base[mode];
				end else begin
					case ($urandom_range(9))
						0, 1, 2: base = '0;
						3:       base = RadixHex;
						4:       base = $urandom_range(1) ? RadixOne : RadW'($urandom_range(37, 63));
						default: base = RadW'($urandom_range(2, 36));
					endcase
				end
				set_parse_mode(base, 1'($urandom_range(1)));
				sent = 0;
				while (sent < 55) begin
					s = random_text();
					send_bytes(s);
					sent += s.size();
				end
				// long receiver hold-off while characters keep coming
				if (mode == 0 && k == 0) begin
					hold_req = 1'b1;
					repeat (12) send_bytes(random_text());
					drain();
				end
			end
		end
		drain();

		$display("Sent %0d strings in %0d beats, %0d results checked, %0d mismatches",
			tracker.strings, beats, tracker.checked, tracker.mismatches);
		$display("Covered radix detect, bases 2..36 and invalid, both sign modes, long hold-off");
		if (tracker.mismatches == 0) begin
			$display("tb_text_to_integer_parser passed");
		end else begin
			$display("tb_text_to_integer_parser failed");
		end
		$finish;
	end

endmodule
